// ----- hw/rtl/serial_servo_command_parser_core_defines.svh -----
// Assertion macros shared by the serial servo command parser checkers.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SERIAL_SERVO_COMMAND_PARSER_CORE_DEFINES_SVH
`define SERIAL_SERVO_COMMAND_PARSER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ssp_pkg.sv -----
// Types, constants and the angle conversion function of the servo command parser.
// Depends on nothing; every other file of the parser but the assertion macros header imports it.
package ssp_pkg;

  // Characters that steer the parser.
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Request kinds and event kinds.
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_TICK  = 1'b1;
  localparam logic EV_ANGLE  = 1'b0;
  localparam logic EV_STALE  = 1'b1;

  // Field widths and limits.
  localparam int ACCUM_W = 14;
  localparam int ANGLE_W = 8;
  localparam int TIMER_W = 16;
  localparam logic [ACCUM_W-1:0] ACCUM_MAX  = 14'd9999;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_BASE = 8'd30;

  // Values from this one upward convert to an angle of at least the maximum.
  localparam logic [ACCUM_W-1:0] SAT_VALUE = 14'd1259;
  // Reciprocal of 25 scaled by 2^16; exact floor for dividends below 3775.
  localparam logic [11:0] RECIP_25    = 12'd2622;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MASK  = 2'd3;
  localparam logic [TIMER_W-1:0] RST_STALE_LIMIT = 16'd100;
  localparam logic [ANGLE_W-1:0] RST_CLAMP_LOW   = 8'd40;
  localparam logic [ANGLE_W-1:0] RST_CLAMP_HIGH  = 8'd140;
  localparam logic [7:0]         RST_CLAMP_MASK  = 8'd12;

  // Current register settings.
  typedef struct packed {
    logic [TIMER_W-1:0] stale_limit_ms;
    logic [ANGLE_W-1:0] clamp_low;
    logic [ANGLE_W-1:0] clamp_high;
    logic [7:0]         clamp_mask;
  } cfg_t;

  // One registered input request on its way to the parser.
  typedef struct packed {
    logic       valid;
    logic       req_type;
    logic [7:0] data_byte;
  } stage_t;

  // Unclamped angle floor(3*value/25)+30, saturated to the maximum angle.
  function automatic logic [ANGLE_W-1:0] raw_angle(input logic [ACCUM_W-1:0] value);
    logic [11:0]        tripled;
    logic [23:0]        prod;
    logic [ANGLE_W-1:0] res;
    tripled = 12'(value[10:0]) * 12'd3;
    prod    = 24'(tripled) * 24'(RECIP_25);
    if (value >= SAT_VALUE) begin
      res = ANGLE_MAX;
    end else begin
      res = prod[23:16] + ANGLE_BASE;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/ssp_if.sv -----
// Handshake interfaces of the servo command parser: input, result and register write.
// Depends on ssp_pkg for the register port widths.
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface ssp_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [2:0] channel;
  logic [7:0] angle_deg;
  modport source (output valid, event_kind, channel, angle_deg, input ready);
  modport sink (input valid, event_kind, channel, angle_deg, output ready);
endinterface

interface ssp_cfg_if;
  import ssp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/serial_servo_command_parser_core.sv -----
// Top level of the serial servo command parser.
// Depends on ssp_pkg, the ssp interfaces, ssp_cfg_regs, ssp_in_stage and ssp_parse.

// The parser takes one request per clock: a received serial byte or a millisecond
// tick. Each request passes through two registers, the input register and the result
// register. A request is taken into the input register when it is accepted, and its
// result, if it has one, goes into the result register when the request moves on,
// which waits while an earlier result in the result register has not been taken.
// A new request can be accepted in every cycle while the result side keeps taking
// results; while a result waits, one more request can still be held in the input
// register before the input stalls.
// A semicolon sends the angle of the field it closes to the next servo channel, if one
// is left, and a tick that reaches the stale limit sends one stale event. The rate is
// set by the single parse step between those two registers, which holds one angle
// conversion multiply. Registers may be written only while no request is in flight.
module serial_servo_command_parser_core #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  ssp_in_if.sink    in_ch,
  ssp_out_if.source out_ch,
  ssp_cfg_if.sink   cfg_ch
);
  import ssp_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  // Register file.
  ssp_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Input register.
  ssp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  // Parser and result register.
  ssp_parse #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .cfg     (cfg),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

// ----- hw/rtl/ssp_cfg_regs.sv -----
// Configuration registers of the servo command parser.
// Depends on ssp_pkg and the ssp_cfg_if interface.
module ssp_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  ssp_cfg_if.sink       cfg_ch,
  output ssp_pkg::cfg_t cfg
);
  import ssp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;

  // Register select.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_STALE_LIMIT: cfg_nxt.stale_limit_ms = cfg_ch.data;
        CFG_CLAMP_LOW:   cfg_nxt.clamp_low      = cfg_ch.data[ANGLE_W-1:0];
        CFG_CLAMP_HIGH:  cfg_nxt.clamp_high     = cfg_ch.data[ANGLE_W-1:0];
        CFG_CLAMP_MASK:  cfg_nxt.clamp_mask     = cfg_ch.data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stale_limit_ms <= RST_STALE_LIMIT;
      cfg_r.clamp_low      <= RST_CLAMP_LOW;
      cfg_r.clamp_high     <= RST_CLAMP_HIGH;
      cfg_r.clamp_mask     <= RST_CLAMP_MASK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/ssp_in_stage.sv -----
// Input register of the servo command parser.
// Depends on ssp_pkg and the ssp_in_if interface.
module ssp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  ssp_in_if.sink          in_ch,
  input  logic            advance,
  output ssp_pkg::stage_t stage
);
  import ssp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic       req_type_r;
  logic [7:0] data_byte_r;
  logic       accept;

  // The register takes a new request whenever it is empty or being drained.
  assign in_ch.ready = !valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r  <= in_ch.req_type;
      data_byte_r <= in_ch.data_byte;
    end
  end

  assign stage.valid     = valid_r;
  assign stage.req_type  = req_type_r;
  assign stage.data_byte = data_byte_r;

endmodule

// ----- hw/rtl/ssp_parse.sv -----
// Parser state, angle conversion and result register of the servo command parser.
// Depends on ssp_pkg and the ssp_out_if interface.
module ssp_parse #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ssp_pkg::stage_t stage,
  input  ssp_pkg::cfg_t   cfg,
  output logic            advance,
  ssp_out_if.source       out_ch
);
  import ssp_pkg::*;

  localparam int FIDX_W = $clog2(NUM_CHANNELS + 1);
  localparam logic [FIDX_W-1:0] FIDX_END = FIDX_W'(NUM_CHANNELS);

  // Parser state.
  logic [ACCUM_W-1:0] acc_r, acc_nxt;
  logic               done_r, done_nxt;
  logic [FIDX_W-1:0]  fidx_r, fidx_nxt;
  logic [TIMER_W-1:0] ms_r, ms_nxt;
  logic               stale_r, stale_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic               kind_r;
  logic [2:0]         chan_r;
  logic [ANGLE_W-1:0] angle_r;

  logic               go;
  logic               res_vld;
  logic               res_kind;
  logic [2:0]         res_chan;
  logic [ANGLE_W-1:0] res_angle;
  logic [TIMER_W-1:0] ms_inc;
  logic [16:0]        acc_mac;
  logic [ACCUM_W-1:0] acc_sat;
  logic [4:0]         fidx_ext;
  logic               clamp_en;
  logic [ANGLE_W-1:0] angle_raw;
  logic [ANGLE_W-1:0] angle_lo;
  logic [ANGLE_W-1:0] angle_fin;
  logic               is_digit;

  // A request moves on when the result register is free or being emptied.
  assign advance = !out_valid_r || out_ch.ready;
  assign go      = stage.valid && advance;

  // Saturating millisecond counter.
  assign ms_inc = (ms_r != '1) ? ms_r + 1'b1 : ms_r;

  // Decimal accumulate, saturating at the largest field value.
  assign is_digit = (stage.data_byte >= CHAR_ZERO) && (stage.data_byte <= CHAR_NINE);
  assign acc_mac  = 17'(acc_r) * 17'd10 + 17'(4'(stage.data_byte - CHAR_ZERO));
  assign acc_sat  = (acc_mac > 17'(ACCUM_MAX)) ? ACCUM_MAX : acc_mac[ACCUM_W-1:0];

  // Angle of the field now ending, with the clamp for masked channels.
  // Crossed limits apply the lower bound first, so the upper one wins.
  assign fidx_ext  = 5'(fidx_r);
  assign clamp_en  = (fidx_ext < 5'd8) && cfg.clamp_mask[fidx_ext[2:0]];
  assign angle_raw = raw_angle(acc_r);
  assign angle_lo  = (clamp_en && angle_raw < cfg.clamp_low) ? cfg.clamp_low : angle_raw;
  assign angle_fin = (clamp_en && angle_lo > cfg.clamp_high) ? cfg.clamp_high : angle_lo;

  // Next state and result for the request in the input register.
  always_comb begin
    acc_nxt   = acc_r;
    done_nxt  = done_r;
    fidx_nxt  = fidx_r;
    ms_nxt    = ms_r;
    stale_nxt = stale_r;
    res_vld   = 1'b0;
    res_kind  = EV_ANGLE;
    res_chan  = 3'd0;
    res_angle = '0;
    if (go) begin
      priority if (stage.req_type == REQ_TICK) begin
        ms_nxt = ms_inc;
        if (!stale_r && ms_inc >= cfg.stale_limit_ms) begin
          stale_nxt = 1'b1;
          res_vld   = 1'b1;
          res_kind  = EV_STALE;
        end
      end else if (stage.data_byte == CHAR_SEMI) begin
        acc_nxt  = '0;
        done_nxt = 1'b0;
        // Fields past the last channel are dropped.
        if (fidx_r < FIDX_END) begin
          fidx_nxt  = fidx_r + 1'b1;
          res_vld   = 1'b1;
          res_chan  = fidx_ext[2:0];
          res_angle = angle_fin;
        end
      end else if (stage.data_byte == CHAR_NL) begin
        acc_nxt   = '0;
        done_nxt  = 1'b0;
        fidx_nxt  = '0;
        ms_nxt    = '0;
        stale_nxt = 1'b0;
      end else if (!done_r && is_digit) begin
        acc_nxt = acc_sat;
      end else begin
        done_nxt = 1'b1;
      end
    end
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      done_r      <= 1'b0;
      fidx_r      <= '0;
      ms_r        <= '0;
      stale_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      done_r      <= done_nxt;
      fidx_r      <= fidx_nxt;
      ms_r        <= ms_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_vld) begin
      kind_r  <= res_kind;
      chan_r  <= res_chan;
      angle_r <= res_angle;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = kind_r;
  assign out_ch.channel    = chan_r;
  assign out_ch.angle_deg  = angle_r;

endmodule

// ----- hw/rtl/ssp_checker.sv -----
// Port-level assertions for the serial servo command parser, bound to its top level.
// Depends on ssp_pkg and the assertion macros header.
`include "serial_servo_command_parser_core_defines.svh"

module ssp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_event_kind,
  input logic [2:0] out_channel,
  input logic [7:0] out_angle_deg
);
  import ssp_pkg::*;

  // A stalled result keeps its payload.
  `SSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_kind) && $stable(out_channel) && $stable(out_angle_deg), "result changed while stalled")

  // Stale events carry no channel and no angle.
  `SSP_ASSERT_SAME(a_stale_zero, out_valid && out_event_kind == EV_STALE, out_channel == 3'd0 && out_angle_deg == '0, "stale event with nonzero payload")

  // Angle updates stay within the servo range.
  `SSP_ASSERT_SAME(a_angle_range, out_valid && out_event_kind == EV_ANGLE, out_angle_deg <= ANGLE_MAX, "angle beyond range")

  // A fresh result follows an accepted request that passed through the input register and then the result register.
  `SSP_ASSERT_SAME(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a request")

endmodule

bind serial_servo_command_parser_core ssp_checker u_ssp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_event_kind (out_ch.event_kind),
  .out_channel    (out_ch.channel),
  .out_angle_deg  (out_ch.angle_deg)
);

// ----- sim/serial_servo_command_parser_core_tb.sv -----
// Self-checking testbench for the serial servo command parser core.
// Drives bytes and ticks through the ssp interfaces and checks every event
// against a cycle-free predictor; depends on ssp_pkg, ssp_if and the core RTL.
module serial_servo_command_parser_core_tb;
  import ssp_pkg::*;

  localparam int CHANNELS       = 8;
  localparam int IDLE_PCT       = 17;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASES         = 7;
  localparam int PHASE_REQUESTS = 100;
  localparam int CYCLE_LIMIT    = 600000;

  // Characters used to build lines, beyond the ones the package names.
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_Z     = 8'h7A;

  typedef enum {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} pressure_t;

  typedef struct packed {
    logic       event_kind;
    logic [2:0] channel;
    logic [7:0] angle_deg;
  } servo_event_t;

  // Tracks parser state and settings, and holds the events still owed by the core.
  class servo_scoreboard;
    logic [TIMER_W-1:0] stale_limit;
    logic [ANGLE_W-1:0] clamp_lo;
    logic [ANGLE_W-1:0] clamp_hi;
    logic [7:0]         clamp_sel;
    logic [ACCUM_W-1:0] accum;
    logic               digits_ended;
    logic [3:0]         next_chan;
    logic [TIMER_W-1:0] ms_idle;
    logic               stale_sent;
    servo_event_t       owed_events[$];
    int                 errors;
    int                 angle_events;
    int                 stale_events;
    int                 reg_writes;

    function new();
      stale_limit  = RST_STALE_LIMIT;
      clamp_lo     = RST_CLAMP_LOW;
      clamp_hi     = RST_CLAMP_HIGH;
      clamp_sel    = RST_CLAMP_MASK;
      accum        = '0;
      digits_ended = 1'b0;
      next_chan    = '0;
      ms_idle      = '0;
      stale_sent   = 1'b0;
      errors       = 0;
      angle_events = 0;
      stale_events = 0;
      reg_writes   = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_STALE_LIMIT: stale_limit = data;
        CFG_CLAMP_LOW:   clamp_lo = data[ANGLE_W-1:0];
        CFG_CLAMP_HIGH:  clamp_hi = data[ANGLE_W-1:0];
        CFG_CLAMP_MASK:  clamp_sel = data[7:0];
        default: ;
      endcase
    endfunction

    // Angle for a field value, with saturation and the per-channel clamp.
    function logic [7:0] servo_angle(input int unsigned value, input int unsigned chan);
      int unsigned a;
      a = (3 * value) / 25 + ANGLE_BASE;
      if (a > ANGLE_MAX) a = ANGLE_MAX;
      if (chan < 8 && clamp_sel[chan]) begin
        if (a < clamp_lo) a = clamp_lo;
        if (a > clamp_hi) a = clamp_hi;
      end
      return a[7:0];
    endfunction

    function void note_request(input logic kind, input logic [7:0] ch);
      servo_event_t ev;
      int unsigned  v;
      if (kind == REQ_TICK) begin
        if (ms_idle != '1) ms_idle++;
        if (!stale_sent && ms_idle >= stale_limit) begin
          stale_sent = 1'b1;
          ev = '{EV_STALE, 3'd0, 8'd0};
          owed_events.push_back(ev);
        end
      end else if (ch == CHAR_SEMI) begin
        v = accum;
        accum = '0;
        digits_ended = 1'b0;
        // Fields past the last channel are dropped without an event.
        if (next_chan < CHANNELS) begin
          ev.event_kind = EV_ANGLE;
          ev.channel    = next_chan[2:0];
          ev.angle_deg  = servo_angle(v, next_chan);
          owed_events.push_back(ev);
          next_chan++;
        end
      end else if (ch == CHAR_NL) begin
        accum = '0;
        digits_ended = 1'b0;
        next_chan = '0;
        ms_idle = '0;
        stale_sent = 1'b0;
      end else if (!digits_ended && ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        v = 32'(accum) * 10 + 32'(ch - CHAR_ZERO);
        if (v > ACCUM_MAX) v = ACCUM_MAX;
        accum = v[ACCUM_W-1:0];
      end else begin
        digits_ended = 1'b1;
      end
    endfunction

    function void check_event(input logic kind, input logic [2:0] chan,
                              input logic [7:0] angle);
      servo_event_t want;
      if (owed_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, actual kind %0d channel %0d angle %0d",
                 $time, kind, chan, angle);
        return;
      end
      want = owed_events.pop_front();
      if (kind !== want.event_kind) begin
        errors++;
        $display("%0t: event_kind mismatch, expected %0d, actual %0d",
                 $time, want.event_kind, kind);
      end
      if (chan !== want.channel) begin
        errors++;
        $display("%0t: channel mismatch, expected %0d, actual %0d",
                 $time, want.channel, chan);
      end
      if (angle !== want.angle_deg) begin
        errors++;
        $display("%0t: angle_deg mismatch, expected %0d, actual %0d",
                 $time, want.angle_deg, angle);
      end
      if (want.event_kind == EV_ANGLE) angle_events++;
      else stale_events++;
    endfunction

    function int pending();
      return owed_events.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   requests_sent = 0;
  bit   sender_steady = 1'b0;
  bit   receiver_steady = 1'b0;
  bit   hold_req = 1'b0;
  servo_scoreboard sb;

  ssp_in_if  in_ch();
  ssp_out_if out_ch();
  ssp_cfg_if cfg_ch();

  serial_servo_command_parser_core #(.NUM_CHANNELS(CHANNELS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Clock with a period of 8.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Abort when the run takes far longer than any correct one would.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("serial_servo_command_parser_core test failed");
    $finish;
  end

  // Result side: random stalls, steady stretches and long hold-offs on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (receiver_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Every accepted result is checked against the oldest owed event.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_event(out_ch.event_kind, out_ch.channel, out_ch.angle_deg);
    end
  end

  // Offers one request, with random idle cycles first unless the sender is steady; returns at a falling edge.
  task automatic send_req(input logic kind, input logic [7:0] value);
    while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= kind;
    in_ch.data_byte <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(kind, value);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] value);
    send_req(REQ_BYTE, value);
  endtask

  task automatic send_tick();
    send_req(REQ_TICK, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_digit();
    send_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
  endtask

  // One semicolon-ended field: plain number, fraction, signed, text-led or empty.
  task automatic send_field();
    int style;
    int n;
    style = $urandom_range(9);
    if (style == 7) send_byte($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
    if (style == 8) repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(CHAR_A, CHAR_Z)));
    if (style != 9) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
      repeat (n) send_digit();
    end
    if (style == 6) begin
      send_byte(CHAR_DOT);
      repeat ($urandom_range(1, 3)) send_digit();
    end
    if ($urandom_range(9) == 0) send_tick();
    send_byte(CHAR_SEMI);
  endtask

  // A command line of up to ten fields, usually closed by a newline.
  task automatic send_line();
    repeat ($urandom_range(0, 10)) send_field();
    if ($urandom_range(9) != 0) send_byte(CHAR_NL);
  endtask

  // Stops offering requests and waits until every owed event has arrived.
  task automatic settle(input int extra);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Registers are only written once the core has gone quiet.
  task automatic apply_settings(input logic [15:0] limit, input logic [7:0] lo,
                                input logic [7:0] hi, input logic [7:0] mask);
    settle(SETTLE_CYCLES);
    cfg_write(CFG_STALE_LIMIT, limit);
    cfg_write(CFG_CLAMP_LOW, 16'(lo));
    cfg_write(CFG_CLAMP_HIGH, 16'(hi));
    cfg_write(CFG_CLAMP_MASK, 16'(mask));
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed lines, with tick bursts and raw noise mixed in.
  task automatic run_traffic(input int target, input pressure_t press);
    int start;
    int r;
    bit pressed;
    start = requests_sent;
    pressed = 1'b0;
    while (requests_sent - start < target) begin
      r = $urandom_range(99);
      if (r < 70) send_line();
      else if (r < 85) repeat ($urandom_range(1, 40)) send_tick();
      else repeat ($urandom_range(1, 8)) send_req(1'($urandom_range(1)),
                                                  8'($urandom_range(255)));
      if (!pressed && requests_sent - start >= target / 2) begin
        pressed = 1'b1;
        if (press == PRESS_HOLD) hold_req = 1'b1;
        else if (press == PRESS_PAUSE) settle(0);
      end
    end
  endtask

  initial begin : stimulus
    int p;
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_BYTE;
    in_ch.data_byte = 8'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_STALE_LIMIT;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero, saturation, text and sign, fraction, excess fields.
    send_text("0;");
    send_text("12345;");
    send_text("-7;");
    send_text("3.5;");
    send_text(";;;;;");
    send_byte(CHAR_NL);

    // Directed: one stale event per period, re-armed by a newline.
    apply_settings(16'd2, RST_CLAMP_LOW, RST_CLAMP_HIGH, RST_CLAMP_MASK);
    repeat (3) send_tick();
    send_byte(CHAR_NL);
    repeat (2) send_tick();

    // Random phases over extreme, crossed and random settings.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(16'd1, 8'd0, ANGLE_MAX, 8'hFF);
        1: apply_settings(16'hFFFF, ANGLE_MAX, 8'd0, 8'hFF);
        2: apply_settings(16'd0, 8'd90, 8'd90, 8'h55);
        default: apply_settings(16'($urandom_range(1, 60)), 8'($urandom_range(180)),
                                8'($urandom_range(180)), 8'($urandom_range(255)));
      endcase
      sender_steady = (p == 3);
      receiver_steady = (p == 3);
      run_traffic(PHASE_REQUESTS, (p % 2 == 1) ? PRESS_HOLD : PRESS_PAUSE);
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;

    settle(SETTLE_CYCLES);
    $display("Sent %0d requests and %0d register writes over %0d setting phases.",
             requests_sent, sb.reg_writes, PHASES + 2);
    $display("Checked %0d angle updates and %0d stale events.",
             sb.angle_events, sb.stale_events);
    if (sb.errors == 0) begin
      $display("serial_servo_command_parser_core test passed");
    end else begin
      $display("serial_servo_command_parser_core test failed");
    end
    $finish;
  end

endmodule
